FILE: design/siao_pkg.sv
// Package for the small integer ALU: opcodes, result kinds, stage control word.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package siao_pkg;

    localparam int SIAO_VALUE_BITS = 32;

    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_SUB   = 5'd1;
    localparam logic [4:0] OP_LT    = 5'd2;
    localparam logic [4:0] OP_GT    = 5'd3;
    localparam logic [4:0] OP_LE    = 5'd4;
    localparam logic [4:0] OP_GE    = 5'd5;
    localparam logic [4:0] OP_EQ    = 5'd6;
    localparam logic [4:0] OP_NE    = 5'd7;
    localparam logic [4:0] OP_MUL   = 5'd8;
    localparam logic [4:0] OP_QUO   = 5'd9;
    localparam logic [4:0] OP_REM   = 5'd10;
    localparam logic [4:0] OP_AND   = 5'd11;
    localparam logic [4:0] OP_XOR   = 5'd12;
    localparam logic [4:0] OP_EQ2   = 5'd13;
    localparam logic [4:0] OP_SHIFT = 5'd19;

    typedef enum logic [1:0] {
        KIND_INT  = 2'd0,
        KIND_BOOL = 2'd1,
        KIND_NIL  = 2'd2
    } kind_t;

    // Control word that travels with each item down the pipeline.
    typedef struct packed {
        kind_t       kind;
        logic        flag;
        logic        is_div;
        logic        is_quo;
        logic        q_neg;
        logic        r_neg;
        logic [63:0] res;
    } siao_ctl_t;

endpackage

FILE: design/siao_if.sv
// Request and response channel interfaces for the small integer ALU.
// Depends on siao_pkg for the result kind type.
`timescale 1ns / 1ps

interface siao_req_if;
    logic               valid;
    logic               ready;
    logic [4:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface siao_rsp_if;
    logic               valid;
    logic               ready;
    siao_pkg::kind_t    result_kind;
    logic signed [31:0] int_result;
    logic               bool_result;

    modport source (output valid, result_kind, int_result, bool_result, input ready);
    modport sink   (input valid, result_kind, int_result, bool_result, output ready);
endinterface

FILE: design/small_integer_alu_overflow.sv
// Small integer ALU with overflow detection, fully pipelined top level.
// Depends on siao_pkg and the siao_req_if / siao_rsp_if interfaces.
`timescale 1ns / 1ps

// One request word in, one response word out, one word per clock sustained.
// Every opcode takes the same path through the pipe: a decode stage
// (add, compare, logic, shift, 32x32 multiply and divider operand prep), one
// restoring-division stage per operand bit, and an output stage that signs
// the quotient or remainder and tests the VALUE_BITS range. The whole pipe
// advances whenever the output register is empty or being taken; while a
// finished response waits there unaccepted, the pipe holds and the request
// side drops ready.
// Nil is returned for arithmetic overflow, a zero divisor and min / -1.
module small_integer_alu_overflow #(
    parameter int VALUE_BITS = siao_pkg::SIAO_VALUE_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    siao_req_if.sink   req,
    siao_rsp_if.source rsp
);
    import siao_pkg::*;

    // Operand width: low bits when narrower than 32, else the 32-bit value.
    localparam int OW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int NS = OW;
    localparam logic signed [63:0] HI = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] LO = -HI - 64'sd1;
    localparam logic signed [63:0] W64 = 64'(VALUE_BITS);

    logic advance;

    // Stage registers: index 0 is decode, 1..NS are division steps.
    logic              vld_reg [0:NS];
    siao_ctl_t         ctl_reg [0:NS];
    logic [OW-1:0]     num_reg [0:NS];
    logic [OW-1:0]     den_reg [0:NS];
    logic [OW-1:0]     rem_reg [0:NS];

    logic              out_vld_reg;
    kind_t             out_kind_reg;
    logic [31:0]       out_int_reg;
    logic              out_bool_reg;

    assign advance   = !out_vld_reg || rsp.ready;
    assign req.ready = advance;

    // ---------------- decode stage ----------------
    logic signed [OW-1:0]       a;
    logic signed [OW-1:0]       b;
    logic signed [63:0]         a64;
    logic signed [63:0]         b64;
    logic signed [63:0]         nb64;
    logic signed [VALUE_BITS-1:0] aw;
    logic signed [VALUE_BITS-1:0] shw;
    logic signed [2*OW-1:0]     prod;
    siao_ctl_t                  ctl_next;
    logic [OW-1:0]              amag;
    logic [OW-1:0]              bmag;

    assign a    = req.operand_a[OW-1:0];
    assign b    = req.operand_b[OW-1:0];
    assign a64  = 64'(a);
    assign b64  = 64'(b);
    assign nb64 = -b64;
    assign aw   = VALUE_BITS'(a);
    assign prod = (2*OW)'(a) * (2*OW)'(b);
    assign amag = a[OW-1] ? OW'(-a) : OW'(a);
    assign bmag = b[OW-1] ? OW'(-b) : OW'(b);

    always_comb
    begin
        if (!b[OW-1])
        begin
            shw = (b64 >= W64) ? '0 : (aw << b64[5:0]);
        end
        else
        begin
            // Keep both arms signed so the right shift fills with the sign.
            shw = (nb64 >= W64) ? $signed({VALUE_BITS{aw[VALUE_BITS-1]}})
                                : (aw >>> nb64[5:0]);
        end
    end

    always_comb
    begin
        ctl_next        = '0;
        ctl_next.kind   = KIND_INT;
        ctl_next.res    = a64;
        ctl_next.q_neg  = a[OW-1] ^ b[OW-1];
        ctl_next.r_neg  = a[OW-1];
        ctl_next.is_quo = (req.req_type == OP_QUO);
        unique case (req.req_type)
            OP_ADD:   ctl_next.res = a64 + b64;
            OP_SUB:   ctl_next.res = a64 - b64;
            OP_MUL:   ctl_next.res = 64'(prod);
            OP_AND:   ctl_next.res = a64 & b64;
            OP_XOR:   ctl_next.res = a64 ^ b64;
            OP_SHIFT: ctl_next.res = 64'(shw);
            OP_LT:
            begin
                ctl_next.kind = KIND_BOOL;
                ctl_next.flag = (a < b);
            end
            OP_GT:
            begin
                ctl_next.kind = KIND_BOOL;
                ctl_next.flag = (a > b);
            end
            OP_LE:
            begin
                ctl_next.kind = KIND_BOOL;
                ctl_next.flag = (a <= b);
            end
            OP_GE:
            begin
                ctl_next.kind = KIND_BOOL;
                ctl_next.flag = (a >= b);
            end
            OP_EQ, OP_EQ2:
            begin
                ctl_next.kind = KIND_BOOL;
                ctl_next.flag = (a == b);
            end
            OP_NE:
            begin
                ctl_next.kind = KIND_BOOL;
                ctl_next.flag = (a != b);
            end
            OP_QUO, OP_REM:
            begin
                // Zero divisor, and min / -1 when the operand spans the full width.
                if ((b64 == 64'sd0) || ((OW == VALUE_BITS) && (a64 == LO) && (b64 == -64'sd1)))
                begin
                    ctl_next.kind = KIND_NIL;
                end
                else
                begin
                    ctl_next.is_div = 1'b1;
                end
            end
            default:  ctl_next.res = a64;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl_reg[0] <= ctl_next;
            num_reg[0] <= amag;
            den_reg[0] <= bmag;
            rem_reg[0] <= '0;
        end
    end

    // ---------------- division steps, one quotient bit each ----------------
    for (genvar k = 1; k <= NS; k++)
    begin : g_div
        logic [OW:0]   trial;
        logic          ge;
        logic [OW-1:0] rem_next;
        logic [OW-1:0] num_next;

        assign trial    = {rem_reg[k-1], num_reg[k-1][OW-1]};
        assign ge       = (trial >= {1'b0, den_reg[k-1]});
        assign rem_next = ge ? OW'(trial - {1'b0, den_reg[k-1]}) : trial[OW-1:0];
        if (OW > 1)
        begin : g_wide
            assign num_next = {num_reg[k-1][OW-2:0], ge};
        end
        else
        begin : g_narrow
            assign num_next = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                num_reg[k] <= num_next;
                rem_reg[k] <= rem_next;
            end
        end
    end

    // ---------------- output stage: sign the division, range test ----------------
    siao_ctl_t          fin;
    logic [OW-1:0]      mag;
    logic               neg;
    logic signed [63:0] val;
    kind_t              kind_next;

    assign fin = ctl_reg[NS];
    assign mag = fin.is_quo ? num_reg[NS] : rem_reg[NS];
    assign neg = fin.is_quo ? fin.q_neg : fin.r_neg;

    always_comb
    begin
        val = fin.res;
        if (fin.is_div)
        begin
            val = neg ? -$signed(64'(mag)) : $signed(64'(mag));
        end
        kind_next = fin.kind;
        if ((fin.kind == KIND_INT) && ((val < LO) || (val > HI)))
        begin
            kind_next = KIND_NIL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_kind_reg <= kind_next;
            out_int_reg  <= (kind_next == KIND_INT) ? val[31:0] : 32'd0;
            out_bool_reg <= (kind_next == KIND_BOOL) && fin.flag;
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.result_kind = out_kind_reg;
    assign rsp.int_result  = out_int_reg;
    assign rsp.bool_result = out_bool_reg;

endmodule

FILE: design/siao_checker.sv
// Port-level checker for the small integer ALU, bound to the top level.
// Depends on siao_pkg for the result kind codes.
`timescale 1ns / 1ps

module siao_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        in_ready,
    input logic [1:0]  result_kind,
    input logic [31:0] int_result,
    input logic        bool_result
);
    import siao_pkg::*;

    // Hold a stalled response word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind))
        else $error("response dropped or changed while stalled");

    // Accept requests whenever the output slot is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request side blocked with empty output");

    a_bool: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bool_result |-> result_kind == KIND_BOOL)
        else $error("boolean flag set on non-boolean result");

    a_int: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (int_result != 32'd0) |-> result_kind == KIND_INT)
        else $error("integer payload on non-integer result");

endmodule

bind small_integer_alu_overflow siao_checker u_siao_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .in_ready    (req.ready),
    .result_kind (rsp.result_kind),
    .int_result  (rsp.int_result),
    .bool_result (rsp.bool_result)
);

FILE: tb/siao_tb_pkg.sv
// Testbench package for the small integer ALU: expected-result word type.
// Depends on siao_pkg for the result kind type.
`timescale 1ns / 1ps

package siao_tb_pkg;

    typedef struct packed {
        siao_pkg::kind_t    kind;
        logic signed [31:0] value;
        logic               truth;
    } alu_answer_t;

endpackage

FILE: tb/siao_checker.sv
// Checker for the small integer ALU: predicts each accepted request word
// and compares response words in order. Depends on siao_pkg, siao_tb_pkg.
`timescale 1ns / 1ps

module siao_tb_checker #(
    parameter int VALUE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_ready,
    input  logic [4:0] req_type,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic       rsp_valid,
    input  logic       rsp_ready,
    input  logic [1:0] result_kind,
    input  logic [31:0] int_result,
    input  logic       bool_result,
    output int         errors,
    output int         pending
);
    import siao_pkg::*;
    import siao_tb_pkg::*;

    alu_answer_t answers_due[$];

    function automatic longint narrow(longint v);
        longint m;
        m = v << (64 - VALUE_BITS);
        return m >>> (64 - VALUE_BITS);
    endfunction

    function automatic alu_answer_t alu_predict(logic [4:0] op, logic [31:0] ra,
                                                logic [31:0] rb);
        longint a, b, r, hi, lo, m;
        alu_answer_t ans;
        hi = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
        lo = -hi - 1;
        a = longint'($signed(ra));
        b = longint'($signed(rb));
        if (VALUE_BITS < 32)
        begin
            a = narrow(a);
            b = narrow(b);
        end
        ans.kind = KIND_INT;
        ans.truth = 1'b0;
        r = 0;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_LT: begin ans.kind = KIND_BOOL; ans.truth = a < b; end
            OP_GT: begin ans.kind = KIND_BOOL; ans.truth = a > b; end
            OP_LE: begin ans.kind = KIND_BOOL; ans.truth = a <= b; end
            OP_GE: begin ans.kind = KIND_BOOL; ans.truth = a >= b; end
            OP_EQ, OP_EQ2: begin ans.kind = KIND_BOOL; ans.truth = a == b; end
            OP_NE: begin ans.kind = KIND_BOOL; ans.truth = a != b; end
            OP_QUO, OP_REM:
                if (b == 0 || (a == lo && b == -1))
                    ans.kind = KIND_NIL;
                else
                    r = (op == OP_QUO) ? a / b : a % b;
            OP_AND: r = a & b;
            OP_XOR: r = a ^ b;
            OP_SHIFT:
                if (b < 0)
                begin
                    m = -b;
                    r = (m >= VALUE_BITS) ? (a < 0 ? -1 : 0) : a >>> m;
                end
                else if (b >= VALUE_BITS)
                    r = 0;
                else
                    r = narrow(a << b);
            default: r = a;
        endcase
        if (ans.kind == KIND_INT && (r < lo || r > hi))
            ans.kind = KIND_NIL;
        ans.value = (ans.kind == KIND_INT) ? r[31:0] : 32'd0;
        return ans;
    endfunction

    assign pending = answers_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        alu_answer_t want;
        if (!rst_n)
        begin
            errors <= 0;
            answers_due.delete();
        end
        else
        begin
            if (req_valid && req_ready)
                answers_due.push_back(alu_predict(req_type, operand_a, operand_b));
            if (rsp_valid && rsp_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t: response word with none due: kind %0d int %0d bool %0d",
                             $time, result_kind, $signed(int_result), bool_result);
                    errors <= errors + 1;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (want.kind !== result_kind || want.value !== int_result
                        || want.truth !== bool_result)
                    begin
                        $display("%0t: mismatch expected kind %0d int %0d bool %0d, got kind %0d int %0d bool %0d",
                                 $time, want.kind, want.value, want.truth,
                                 result_kind, $signed(int_result), bool_result);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/small_integer_alu_overflow_tb.sv
// Top of the small integer ALU testbench: clock, reset, stimulus, verdict.
// Depends on siao_pkg, siao_if, siao_checker and the block itself.
`timescale 1ns / 1ps

module small_integer_alu_overflow_tb;
    import siao_pkg::*;

    localparam int LATENCY = 34;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors, pending;
    int   cycles = 0;
    int   send_idle = 0;   // percent chance the sender idles a cycle
    int   recv_idle = 0;   // percent chance the receiver stalls a cycle
    bit   hold_off = 1'b0; // long receiver stall in progress

    siao_req_if req ();
    siao_rsp_if rsp ();

    small_integer_alu_overflow uut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    siao_tb_checker #(.VALUE_BITS(SIAO_VALUE_BITS)) u_tb_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req.valid), .req_ready(req.ready), .req_type(req.req_type),
        .operand_a(req.operand_a), .operand_b(req.operand_b),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .result_kind(rsp.result_kind),
        .int_result(rsp.int_result), .bool_result(rsp.bool_result),
        .errors(errors), .pending(pending)
    );

    always #1 clk = ~clk;

    // Guard the whole run against a hang.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off completely during pressure.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
        end
    end

    // Pick an operand from a narrow range near the interesting edges five times in eight.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000 + $urandom_range(2);
            1: return 32'h7fff_ffff - $urandom_range(2);
            2: return $urandom_range(4) - 2;
            3: return $urandom_range(80) - 40;
            4: return $urandom_range(65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_word(logic [4:0] op, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= op;
        req.operand_a <= a;
        req.operand_b <= b;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(int count);
        logic [4:0] op;
        for (int i = 0; i < count; i++)
        begin
            // Mostly listed opcodes; now and then any 5-bit code.
            if ($urandom_range(9) == 0)
                op = 5'($urandom_range(31));
            else
            begin
                op = 5'($urandom_range(14));
                if (op == 5'd14)
                    op = OP_SHIFT;
            end
            send_word(op, pick_operand(), pick_operand());
        end
        req.valid <= 1'b0;
    endtask

    initial
    begin
        logic [4:0] ops [15] = '{OP_ADD, OP_SUB, OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ,
                                OP_NE, OP_MUL, OP_QUO, OP_REM, OP_AND, OP_XOR,
                                OP_EQ2, OP_SHIFT};
        req.valid = 1'b0;
        req.req_type = OP_ADD;
        req.operand_a = '0;
        req.operand_b = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every opcode on the extremes, then each special case.
        foreach (ops[i])
            send_word(ops[i], 32'h7fff_ffff, 32'h8000_0000);
        send_word(OP_ADD, 32'h7fff_ffff, 32'd1);
        send_word(OP_MUL, 32'h8000_0000, 32'hffff_ffff);
        send_word(OP_QUO, 32'd7, 32'd0);
        send_word(OP_REM, 32'h8000_0000, 32'hffff_ffff);
        send_word(OP_QUO, 32'hffff_fff9, 32'd2);
        send_word(OP_SHIFT, 32'h8000_0001, 32'd40);
        send_word(OP_SHIFT, 32'h8000_0001, 32'hffff_ffc0);
        send_word(OP_SHIFT, 32'h0000_0003, 32'd31);
        send_word(5'd31, 32'h1234_5678, 32'd0);
        req.valid <= 1'b0;

        send_idle = 26; recv_idle = 69;
        send_random(450);

        // Pressure: hold the receiver off while words keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (150) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(60);
        join

        send_idle = 69; recv_idle = 26;
        send_random(400);
        send_idle = 0; recv_idle = 0;
        send_random(420);

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
